// ===== rtl/fcar_pkg.sv =====
// Shared types and constants for the framed command ack/retransmit block.
`timescale 1ns / 1ps
package fcar_pkg;

  localparam int CMD_LEN         = 4;
  localparam int CMD_IDX_W       = 2;
  localparam int CMD_CNT_W       = 3;
  localparam int SAMPLE_W        = 12;
  localparam int TIMEOUT_W       = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd3000;

  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef logic [CMD_LEN-1:0][7:0] cmd_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
  } req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_SEND = 2'b10
  } back_state_t;

endpackage

// ===== rtl/fcar_front.sv =====
// Front end: command parser, link state and retransmit timer.
`timescale 1ns / 1ps
module fcar_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic                                func,
  input  logic [7:0]                          rx_byte,
  input  logic [fcar_pkg::SAMPLE_W-1:0]       adc_sample,
  input  logic [fcar_pkg::TIMEOUT_W-1:0]      timeout,
  output logic                                push,
  output fcar_pkg::req_t                      req
);

  logic                              storing_r, storing_nxt;
  logic [fcar_pkg::CMD_CNT_W-1:0]    count_r, count_nxt;
  fcar_pkg::cmd_t                    frame_r, frame_nxt;
  fcar_pkg::cmd_t                    head_r, head_nxt;
  logic                              waiting_r, waiting_nxt;
  logic [fcar_pkg::SAMPLE_W-1:0]     latched_r, latched_nxt;
  logic [fcar_pkg::TIMEOUT_W-1:0]    counter_r, counter_nxt;
  logic [fcar_pkg::TIMEOUT_W-1:0]    dec;
  logic                              tick_emit;

  function automatic logic is_rst(input fcar_pkg::cmd_t h);
    return h[0] == fcar_pkg::CH_R && h[1] == fcar_pkg::CH_S &&
           h[2] == fcar_pkg::CH_T && h[3] == fcar_pkg::CH_NUL;
  endfunction

  function automatic logic is_ok(input fcar_pkg::cmd_t h);
    return h[0] == fcar_pkg::CH_O && h[1] == fcar_pkg::CH_K &&
           h[2] == fcar_pkg::CH_NUL;
  endfunction

  always_comb begin
    storing_nxt = storing_r;
    count_nxt   = count_r;
    frame_nxt   = frame_r;
    head_nxt    = head_r;
    waiting_nxt = waiting_r;
    latched_nxt = latched_r;
    counter_nxt = counter_r;
    push        = 1'b0;
    req.sample  = latched_r;
    tick_emit   = 1'b0;
    dec         = (counter_r != '0) ? counter_r - 1'b1 : '0;

    if (accept && !func) begin
      if (!storing_r) begin
        if (rx_byte == fcar_pkg::CH_BANG) begin
          storing_nxt = 1'b1;
          count_nxt   = '0;
          frame_nxt   = '0;
        end
      end else if (rx_byte == fcar_pkg::CH_HASH) begin
        storing_nxt = 1'b0;
        head_nxt    = frame_r;
      end else if (count_r < fcar_pkg::CMD_CNT_W'(fcar_pkg::CMD_LEN)) begin
        frame_nxt[count_r[fcar_pkg::CMD_IDX_W-1:0]] = rx_byte;
        count_nxt = count_r + 1'b1;
      end
    end

    if (accept && func && waiting_r) begin
      if (dec == '0) begin
        counter_nxt = timeout;
        push        = 1'b1;
        tick_emit   = 1'b1;
      end else begin
        counter_nxt = dec;
      end
    end

    if (accept && !tick_emit) begin
      if (!waiting_r) begin
        if (is_rst(head_nxt)) begin
          latched_nxt = adc_sample;
          waiting_nxt = 1'b1;
          counter_nxt = timeout;
          push        = 1'b1;
          req.sample  = adc_sample;
        end
      end else if (is_ok(head_nxt)) begin
        waiting_nxt = 1'b0;
        head_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      storing_r <= 1'b0;
      count_r   <= '0;
      frame_r   <= '0;
      head_r    <= '0;
      waiting_r <= 1'b0;
      latched_r <= '0;
      counter_r <= '0;
    end else begin
      storing_r <= storing_nxt;
      count_r   <= count_nxt;
      frame_r   <= frame_nxt;
      head_r    <= head_nxt;
      waiting_r <= waiting_nxt;
      latched_r <= latched_nxt;
      counter_r <= counter_nxt;
    end
  end

endmodule

// ===== rtl/fcar_queue.sv =====
// Short request queue between front end and report sender.
`timescale 1ns / 1ps
module fcar_queue #(
  parameter int DEPTH = fcar_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  fcar_pkg::req_t       wr_req,
  input  logic                 pop,
  output fcar_pkg::req_t       rd_req,
  output fcar_pkg::q_status_t  status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fcar_pkg::req_t     mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rd_req       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_req;
    end
  end

endmodule

// ===== rtl/fcar_back.sv =====
// Report sender: decimal conversion and byte sequencing into the output register.
`timescale 1ns / 1ps
module fcar_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fcar_pkg::req_t       rd_req,
  input  fcar_pkg::q_status_t  q_status,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast
);

  localparam logic [3:0] SLOT_FIRST_DIGIT = 4'd6;
  localparam logic [3:0] SLOT_HUNDREDS    = 4'd7;
  localparam logic [3:0] SLOT_TENS        = 4'd8;
  localparam logic [3:0] SLOT_ONES        = 4'd9;
  localparam logic [3:0] SLOT_PREFIX_END  = 4'd5;
  localparam logic [3:0] SLOT_LAST        = 4'd13;
  localparam logic [1:0] CONV_DONE        = 2'd3;

  fcar_pkg::back_state_t          state_r, state_nxt;
  logic [3:0]                     slot_r, slot_nxt;
  logic [1:0]                     step_r, step_nxt;
  logic [fcar_pkg::SAMPLE_W-1:0]  rem_r, rem_nxt;
  logic [3:0]                     d3_r, d2_r, d1_r;
  logic [3:0]                     d3_nxt, d2_nxt, d1_nxt;
  logic                           valid_r, valid_nxt;
  logic [7:0]                     byte_r, byte_nxt;
  logic                           last_r, last_nxt;
  logic [fcar_pkg::SAMPLE_W-1:0]  div;
  logic [3:0]                     digit;
  logic                           emit;
  logic [7:0]                     slot_byte;
  logic [3:0]                     start_slot;

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;
  assign emit       = (state_r == fcar_pkg::BK_SEND) && (!valid_r || out_tready);
  assign pop        = (state_r == fcar_pkg::BK_IDLE) && !q_status.empty;

  always_comb begin
    case (step_r)
      2'd0:    div = 12'd1000;
      2'd1:    div = 12'd100;
      default: div = 12'd10;
    endcase
    digit = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({2'b00, rem_r} >= 14'(k) * {2'b00, div}) begin
        digit = 4'(k);
      end
    end
  end

  always_comb begin
    if (d3_r != '0) begin
      start_slot = SLOT_FIRST_DIGIT;
    end else if (d2_r != '0) begin
      start_slot = SLOT_HUNDREDS;
    end else if (d1_r != '0) begin
      start_slot = SLOT_TENS;
    end else begin
      start_slot = SLOT_ONES;
    end
  end

  always_comb begin
    case (slot_r)
      4'd0:    slot_byte = fcar_pkg::CH_BANG;
      4'd1:    slot_byte = fcar_pkg::CH_A;
      4'd2:    slot_byte = fcar_pkg::CH_D;
      4'd3:    slot_byte = fcar_pkg::CH_C;
      4'd4:    slot_byte = fcar_pkg::CH_EQ;
      4'd5:    slot_byte = fcar_pkg::CH_SPACE;
      4'd6:    slot_byte = fcar_pkg::CH_ZERO + {4'd0, d3_r};
      4'd7:    slot_byte = fcar_pkg::CH_ZERO + {4'd0, d2_r};
      4'd8:    slot_byte = fcar_pkg::CH_ZERO + {4'd0, d1_r};
      4'd9:    slot_byte = fcar_pkg::CH_ZERO + {4'd0, rem_r[3:0]};
      4'd10:   slot_byte = fcar_pkg::CH_HASH;
      4'd11:   slot_byte = fcar_pkg::CH_SPACE;
      4'd12:   slot_byte = fcar_pkg::CH_CR;
      default: slot_byte = fcar_pkg::CH_LF;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    d3_nxt    = d3_r;
    d2_nxt    = d2_r;
    d1_nxt    = d1_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;

    if (pop) begin
      state_nxt = fcar_pkg::BK_SEND;
      slot_nxt  = '0;
      step_nxt  = '0;
      rem_nxt   = rd_req.sample;
    end

    if (state_r == fcar_pkg::BK_SEND && step_r != CONV_DONE) begin
      case (step_r)
        2'd0:    d3_nxt = digit;
        2'd1:    d2_nxt = digit;
        default: d1_nxt = digit;
      endcase
      rem_nxt  = rem_r - fcar_pkg::SAMPLE_W'({8'd0, digit} * div);
      step_nxt = step_r + 1'b1;
    end

    if (emit) begin
      valid_nxt = 1'b1;
      byte_nxt  = slot_byte;
      last_nxt  = (slot_r == SLOT_LAST);
      if (slot_r == SLOT_LAST) begin
        state_nxt = fcar_pkg::BK_IDLE;
      end else if (slot_r == SLOT_PREFIX_END) begin
        slot_nxt = start_slot;
      end else begin
        slot_nxt = slot_r + 1'b1;
      end
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcar_pkg::BK_IDLE;
      slot_r  <= '0;
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    d3_r   <= d3_nxt;
    d2_r   <= d2_nxt;
    d1_r   <= d1_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

endmodule

// ===== rtl/framed_command_ack_retransmit.sv =====
// Path: with the sender idle, a request that triggers a report is written into the report
// queue, popped by the sender's load step, and its first byte then enters the output register.
// Throughput: one input request per cycle; a report streams 11 to 14 bytes at one per cycle
// while out_tready allows, with a gap between reports for the sender's load step.
// Input stalls only while the report queue (QUEUE_DEPTH entries) is full.
// Reset: synchronous active-low rst_n clears parser, link state, queue and output;
// timeout returns to 3000 ticks.
`timescale 1ns / 1ps
module framed_command_ack_retransmit #(
  parameter int QUEUE_DEPTH = fcar_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] rx_byte, [19:8] adc_sample, [23:20] zero
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] tx_byte
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [fcar_pkg::TIMEOUT_W-1:0] timeout_r;
  logic                           in_accept;
  logic                           push;
  logic                           pop;
  fcar_pkg::req_t                 wr_req;
  fcar_pkg::req_t                 rd_req;
  fcar_pkg::q_status_t            q_status;

  assign in_tready = !q_status.full;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= fcar_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  fcar_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .func       (in_tuser),
    .rx_byte    (in_tdata[7:0]),
    .adc_sample (in_tdata[19:8]),
    .timeout    (timeout_r),
    .push       (push),
    .req        (wr_req)
  );

  fcar_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_req (wr_req),
    .pop    (pop),
    .rd_req (rd_req),
    .status (q_status)
  );

  fcar_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_req     (rd_req),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_status.full))
    else $error("report request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_status.empty))
    else $error("report request popped from empty queue");

  a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata == fcar_pkg::CH_LF))
    else $error("final report byte is not line feed");

  a_first_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=>
      (!out_tvalid || out_tdata == fcar_pkg::CH_BANG))
    else $error("report does not start with bang");
`endif

endmodule

// ===== tb/tb_framed_command_ack_retransmit.sv =====
// Self-checking stream testbench for the framed command receiver with report retransmit.
`timescale 1ns / 1ps
module tb_framed_command_ack_retransmit;
  import fcar_pkg::*;

  localparam int LIMIT = 600000;
  localparam int PHASE_ITEMS = 34;

  typedef enum logic {KIND_BYTE = 1'b0, KIND_TICK = 1'b1} kind_e;
  typedef enum int {CHK_PRED, CHK_NONE, CHK_MSG} chk_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } tx_t;

  typedef struct {
    kind_e       kind;
    logic [7:0]  b;
    logic [11:0] s;
    chk_e        chk;
    string       msg;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [7:0] rx_byte, [19:8] adc_sample, [23:20] zero
  logic        in_tuser = 1'b0; // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] tx_byte
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // predictor state
  bit                   parse_on = 1'b0;
  cmd_t                 frame = '0;
  cmd_t                 head = '0;
  logic [CMD_CNT_W-1:0] n_stored = '0;
  bit                   waiting = 1'b0;
  logic [SAMPLE_W-1:0]  held_sample = '0;
  logic [TIMEOUT_W-1:0] countdown = '0;
  logic [TIMEOUT_W-1:0] timeout_cfg = TIMEOUT_RESET;

  tx_t  step_out[$];
  tx_t  report_q[$];
  row_t dir_rows[$];
  int   errors = 0;
  int   cycles = 0;
  int   burst_left = 0;
  bit   gaps_on = 1'b1;
  bit   hold_req = 1'b0;

  framed_command_ack_retransmit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void queue_report();
    int   v;
    int   dv;
    int   d;
    bit   started;
    byte  msg[$];
    tx_t  r;
    v = held_sample;
    started = 1'b0;
    msg = '{CH_BANG, CH_A, CH_D, CH_C, CH_EQ, CH_SPACE};
    for (dv = 1000; dv >= 1; dv = dv / 10) begin
      d = v / dv;
      v = v - d * dv;
      if (d != 0 || started || dv == 1) begin
        msg.push_back(8'(CH_ZERO + d));
        started = 1'b1;
      end
    end
    msg.push_back(CH_HASH);
    msg.push_back(CH_SPACE);
    msg.push_back(CH_CR);
    msg.push_back(CH_LF);
    foreach (msg[i]) begin
      r.ch = msg[i];
      r.last = (i == msg.size() - 1);
      step_out.push_back(r);
    end
  endfunction

  // advance the link model by one request; returns 1 if the request is not ignored
  function automatic bit link_step(kind_e k, logic [7:0] b, logic [11:0] s);
    bit live;
    step_out.delete();
    live = (k == KIND_BYTE) ? (parse_on || b == CH_BANG) : waiting;
    if (k == KIND_BYTE) begin
      if (!parse_on) begin
        if (b == CH_BANG) begin
          parse_on = 1'b1;
          n_stored = '0;
          frame = '0;
        end
      end else if (b == CH_HASH) begin
        parse_on = 1'b0;
        head = frame;
      end else if (n_stored < CMD_LEN) begin
        frame[n_stored[CMD_IDX_W-1:0]] = b;
        n_stored = n_stored + 1'b1;
      end
    end else if (waiting) begin
      if (countdown > 0) countdown = countdown - 1'b1;
      if (countdown == 0) begin
        countdown = timeout_cfg;
        queue_report();
        return live;
      end
    end
    if (!waiting) begin
      if (head[0] == CH_R && head[1] == CH_S && head[2] == CH_T && head[3] == CH_NUL) begin
        held_sample = s;
        waiting = 1'b1;
        countdown = timeout_cfg;
        queue_report();
      end
    end else if (head[0] == CH_O && head[1] == CH_K && head[2] == CH_NUL) begin
      waiting = 1'b0;
      head = '0;
    end
    return live;
  endfunction

  function automatic void add_row(kind_e k, logic [7:0] b, logic [11:0] s, chk_e chk,
                                  string msg);
    row_t r;
    r.kind = k;
    r.b = b;
    r.s = s;
    r.chk = chk;
    r.msg = msg;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [11:0] pick_sample();
    int marks[6] = '{9, 10, 99, 100, 999, 1000};
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'(marks[$urandom_range(0, 5)]);
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic send_req(input kind_e k, input logic [7:0] b, input logic [11:0] s,
                          input chk_e chk, input string msg, inout int counted);
    tx_t r;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= k;
    in_tdata <= {4'h0, s, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (link_step(k, b, s)) counted++;
    case (chk)
      CHK_PRED: foreach (step_out[i]) report_q.push_back(step_out[i]);
      CHK_MSG: begin
        for (int i = 0; i < msg.len(); i++) begin
          r.ch = msg[i];
          r.last = (i == msg.len() - 1);
          report_q.push_back(r);
        end
      end
      default: ;
    endcase
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
        burst_left = $urandom_range(0, 11);
      end
    end
  endtask

  task automatic drain_reports();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_timeout(logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    timeout_cfg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    tx_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (report_q.size() == 0) begin
        $error("tx_byte: unexpected result, got %h", out_tdata);
        errors++;
      end else begin
        want = report_q.pop_front();
        if (out_tdata !== want.ch) begin
          $error("tx_byte mismatch: expected %h, got %h", want.ch, out_tdata);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("tx_last mismatch: expected %0b, got %0b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern and long hold-off
  initial begin
    int        hold_left;
    int        span;
    int        mode;
    bit [15:0] pat;
    hold_left = 0;
    span = 0;
    mode = 0;
    pat = '1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (span == 0) begin
        span = 64;
        mode = $urandom_range(0, 2);
        pat = $urandom;
      end
      span--;
      pat = {pat[0], pat[15:1]};
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= pat[0];
          default: out_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int          counted;
    int          tmo[5];
    int          n;
    int          r;
    logic [7:0]  seq[$];
    string       msg_max;
    string       msg_zero;
    counted = 0;
    msg_max = "!ADC= 4095# \015\n";
    msg_zero = "!ADC= 0# \015\n";
    tmo = '{2, 1, 65535, 3000, 0};
    tmo[4] = $urandom_range(2, 6);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    write_timeout(16'd1);
    add_row(KIND_TICK, 8'h00, 12'd0, CHK_NONE, "");
    add_row(KIND_BYTE, CH_R, 12'd0, CHK_NONE, "");
    add_row(KIND_BYTE, CH_BANG, 12'd0, CHK_NONE, "");
    add_row(KIND_BYTE, CH_R, 12'd0, CHK_NONE, "");
    add_row(KIND_BYTE, CH_S, 12'd0, CHK_NONE, "");
    add_row(KIND_BYTE, CH_T, 12'd0, CHK_NONE, "");
    add_row(KIND_BYTE, CH_HASH, 12'd4095, CHK_MSG, msg_max);
    add_row(KIND_TICK, 8'hFF, 12'd77, CHK_MSG, msg_max);
    add_row(KIND_BYTE, CH_BANG, 12'd1234, CHK_NONE, "");
    add_row(KIND_BYTE, CH_R, 12'd1234, CHK_NONE, "");
    add_row(KIND_BYTE, CH_S, 12'd1234, CHK_NONE, "");
    add_row(KIND_BYTE, CH_T, 12'd1234, CHK_NONE, "");
    add_row(KIND_BYTE, CH_HASH, 12'd1234, CHK_NONE, "");
    add_row(KIND_BYTE, CH_BANG, 12'd0, CHK_NONE, "");
    add_row(KIND_BYTE, CH_O, 12'd0, CHK_NONE, "");
    add_row(KIND_BYTE, CH_K, 12'd0, CHK_NONE, "");
    add_row(KIND_BYTE, CH_NUL, 12'd0, CHK_NONE, "");
    add_row(KIND_BYTE, CH_BANG, 12'd0, CHK_NONE, "");
    add_row(KIND_BYTE, 8'h59, 12'd0, CHK_NONE, "");
    add_row(KIND_BYTE, CH_HASH, 12'd0, CHK_NONE, "");
    add_row(KIND_BYTE, CH_BANG, 12'd4095, CHK_PRED, "");
    add_row(KIND_BYTE, CH_R, 12'd4095, CHK_PRED, "");
    add_row(KIND_BYTE, CH_S, 12'd4095, CHK_PRED, "");
    add_row(KIND_BYTE, CH_T, 12'd4095, CHK_PRED, "");
    add_row(KIND_BYTE, CH_HASH, 12'd0, CHK_MSG, msg_zero);
    foreach (dir_rows[i])
      send_req(dir_rows[i].kind, dir_rows[i].b, dir_rows[i].s, dir_rows[i].chk,
               dir_rows[i].msg, counted);
    drain_reports();

    for (int p = 0; p < 5; p++) begin
      write_timeout(16'(tmo[p]));
      gaps_on = (p != 2);
      counted = 0;
      if (p == 1) begin
        // hold the receiver while reports pile up behind resend ticks
        hold_req = 1'b1;
        seq = '{CH_BANG, CH_O, CH_K, CH_HASH, CH_BANG, CH_R, CH_S, CH_T, CH_HASH};
        foreach (seq[i]) send_req(KIND_BYTE, seq[i], pick_sample(), CHK_PRED, "", counted);
        repeat (6) send_req(KIND_TICK, 8'($urandom), pick_sample(), CHK_PRED, "", counted);
      end
      while (counted < PHASE_ITEMS) begin
        seq.delete();
        r = $urandom_range(0, 99);
        if (r < 35) begin
          seq = '{CH_BANG, CH_R, CH_S, CH_T, CH_HASH};
        end else if (r < 55) begin
          seq = '{CH_BANG, CH_O, CH_K};
          if ($urandom_range(0, 1)) begin
            seq.push_back(CH_NUL);
            seq.push_back(8'($urandom_range(0, 255)));
          end
          seq.push_back(CH_HASH);
        end else if (r < 75) begin
          n = $urandom_range(1, 5);
          repeat (n) send_req(KIND_TICK, 8'($urandom), pick_sample(), CHK_PRED, "", counted);
        end else if (r < 85) begin
          seq.push_back(CH_BANG);
          repeat ($urandom_range(0, 6)) seq.push_back(8'($urandom_range(0, 255)));
          seq.push_back(CH_HASH);
        end else if (r < 93) begin
          repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom_range(0, 255)));
        end else begin
          case ($urandom_range(0, 3))
            0: seq = '{CH_BANG, CH_R, CH_S, CH_HASH};
            1: seq = '{CH_BANG, CH_R, CH_S, CH_T, CH_K, CH_HASH};
            2: seq = '{CH_BANG, CH_O, CH_HASH};
            default: seq = '{CH_BANG, CH_BANG, CH_R, CH_S, CH_T, CH_HASH};
          endcase
        end
        foreach (seq[i]) send_req(KIND_BYTE, seq[i], pick_sample(), CHK_PRED, "", counted);
        if ($urandom_range(0, 29) == 0) drain_reports();
      end
      drain_reports();
    end

    if (errors == 0 && report_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
